### src/bmf_pkg.sv
package bmf_pkg;

    localparam int RING_ROWS = 10;
    localparam int RING_W    = 4;
    localparam int COL_W     = 13;
    localparam int ROW_W     = 13;
    localparam int CNT_W     = 27;
    localparam int SUM_W     = 15;
    localparam int CFG_W     = 13;
    localparam int MAX_ROWS  = 4096;

    localparam logic [1:0] REG_HALF   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] mean_value;
        logic       row_end;
        logic       image_end;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  half;
        logic [13:0] width;
        logic [12:0] height;
    } geom_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [RING_W-1:0] ring;
        logic              row_end;
        logic              image_end;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [RING_W-1:0] ring;
        logic [COL_W-1:0]  col;
        logic [7:0]        data;
    } wr_t;

    function automatic logic [6:0] window_area(input logic [2:0] h);
        logic [6:0] a;
        unique case (h)
            3'd1:    a = 7'd9;
            3'd2:    a = 7'd25;
            3'd3:    a = 7'd49;
            default: a = 7'd81;
        endcase
        return a;
    endfunction

    // floor(2^16 / area)
    function automatic logic [12:0] area_recip(input logic [2:0] h);
        logic [12:0] r;
        unique case (h)
            3'd1:    r = 13'd7281;
            3'd2:    r = 13'd2621;
            3'd3:    r = 13'd1337;
            default: r = 13'd809;
        endcase
        return r;
    endfunction

endpackage

### src/bmf_front.sv
module bmf_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HALF  = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0] cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  bmf_pkg::in_item_t      s_payload,
    input  logic                   back_busy_i,
    input  logic                   job_ready_i,
    output logic                   job_valid_o,
    output bmf_pkg::job_t          job_o,
    output bmf_pkg::wr_t           wr_o,
    output bmf_pkg::geom_t         geom_o
);

    logic [2:0]  half_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    logic [bmf_pkg::CNT_W-1:0]  pos_reg, ocnt_reg;
    logic [bmf_pkg::COL_W-1:0]  in_col_reg, out_col_reg;
    logic [bmf_pkg::RING_W-1:0] in_ring_reg, out_ring_reg;
    logic [bmf_pkg::ROW_W-1:0]  out_row_reg;
    logic                       q_valid_reg;
    bmf_pkg::job_t              q_job_reg;

    logic [2:0]                h;
    logic [13:0]               w;
    logic [12:0]               ht;
    logic [bmf_pkg::CNT_W-1:0] total, lag;
    logic                      fire, go, emit, is_pix;

    always_comb begin
        if (half_reg == 3'd0) h = 3'd1;
        else if (half_reg > 3'(MAX_HALF)) h = 3'(MAX_HALF);
        else h = half_reg;
        if (width_reg == 11'd0) w = 14'd1;
        else if ({3'b0, width_reg} > 14'(MAX_WIDTH)) w = 14'(MAX_WIDTH);
        else w = {3'b0, width_reg};
        if (height_reg == 13'd0) ht = 13'd1;
        else if ({1'b0, height_reg} > 14'(bmf_pkg::MAX_ROWS)) ht = 13'(bmf_pkg::MAX_ROWS);
        else ht = height_reg;
    end

    assign total  = bmf_pkg::CNT_W'(w) * bmf_pkg::CNT_W'(ht);
    assign lag    = bmf_pkg::CNT_W'(h) * bmf_pkg::CNT_W'(w) + bmf_pkg::CNT_W'(h);
    assign geom_o = '{half: h, width: w, height: ht};

    assign s_ready = !q_valid_reg && !back_busy_i;
    assign fire    = s_valid && s_ready;
    assign is_pix  = s_payload.command == bmf_pkg::CMD_PIXEL;
    assign go      = is_pix ? (pos_reg < total) : (pos_reg >= total && ocnt_reg < total);
    assign emit    = go && pos_reg >= lag && ocnt_reg < total;

    assign wr_o = '{en: fire && go && is_pix, ring: in_ring_reg, col: in_col_reg,
                    data: s_payload.pixel_value};

    assign job_valid_o = q_valid_reg;
    assign job_o       = q_job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg     <= 3'd1;
            width_reg    <= 11'd15;
            height_reg   <= 13'd15;
            pos_reg      <= '0;
            ocnt_reg     <= '0;
            in_col_reg   <= '0;
            in_ring_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ring_reg <= '0;
            q_valid_reg  <= 1'b0;
        end else begin
            if (job_ready_i && q_valid_reg) q_valid_reg <= 1'b0;
            if (cfg_we && cfg_index <= bmf_pkg::REG_HEIGHT) begin
                unique case (cfg_index)
                    bmf_pkg::REG_HALF:   half_reg   <= cfg_data[2:0];
                    bmf_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                    bmf_pkg::REG_HEIGHT: height_reg <= cfg_data[12:0];
                    default: ;
                endcase
                pos_reg      <= '0;
                ocnt_reg     <= '0;
                in_col_reg   <= '0;
                in_ring_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_ring_reg <= '0;
            end else if (fire && go) begin
                pos_reg <= pos_reg + 1'b1;
                if (14'(in_col_reg) + 14'd1 >= w) begin
                    in_col_reg  <= '0;
                    in_ring_reg <= (in_ring_reg == 4'(bmf_pkg::RING_ROWS - 1)) ?
                                   '0 : in_ring_reg + 1'b1;
                end else begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
                if (emit) begin
                    q_valid_reg <= 1'b1;
                    q_job_reg   <= '{row: out_row_reg, col: out_col_reg, ring: out_ring_reg,
                                     row_end: 14'(out_col_reg) == w - 14'd1,
                                     image_end: ocnt_reg == total - 1'b1};
                    ocnt_reg <= ocnt_reg + 1'b1;
                    if (14'(out_col_reg) + 14'd1 >= w) begin
                        out_col_reg  <= '0;
                        out_row_reg  <= out_row_reg + 1'b1;
                        out_ring_reg <= (out_ring_reg == 4'(bmf_pkg::RING_ROWS - 1)) ?
                                        '0 : out_ring_reg + 1'b1;
                    end else begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule

### src/bmf_back.sv
module bmf_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bmf_pkg::geom_t     geom_i,
    input  bmf_pkg::wr_t       wr_i,
    input  logic               job_valid_i,
    input  bmf_pkg::job_t      job_i,
    output logic               job_ready_o,
    output logic               busy_o,
    output logic               m_valid,
    input  logic               m_ready,
    output bmf_pkg::out_item_t m_payload
);

    localparam int DEPTH = bmf_pkg::RING_ROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_DIV1  = 6'b001000,
        ST_DIV2  = 6'b010000,
        ST_HOLD  = 6'b100000
    } state_t;

    logic [7:0] mem [DEPTH];

    state_t                     state_reg;
    logic signed [14:0]         rr_reg, cc_reg, cc0_reg;
    logic [bmf_pkg::RING_W-1:0] ring_reg;
    logic [3:0]                 dr_reg, dc_reg;
    logic [bmf_pkg::SUM_W-1:0]  sum_reg;
    logic                       rd_en_reg;
    logic [7:0]                 rd_data_reg;
    logic [7:0]                 q0_reg, mean_reg;
    logic                       row_end_reg, image_end_reg;
    logic                       out_valid_reg;
    bmf_pkg::out_item_t         out_reg;

    logic [AW-1:0]              wr_addr, rd_addr;
    logic                       in_rng;
    logic [3:0]                 span;
    logic [4:0]                 ring_tmp;
    logic [27:0]                prod;
    logic [bmf_pkg::SUM_W-1:0]  rem;
    logic [6:0]                 area;

    assign wr_addr  = AW'(32'(wr_i.ring) * MAX_WIDTH + 32'(wr_i.col));
    assign rd_addr  = AW'(32'(ring_reg) * MAX_WIDTH + 32'(cc_reg[12:0]));
    assign in_rng   = rr_reg >= 0 && rr_reg < $signed({2'b0, geom_i.height}) &&
                      cc_reg >= 0 && cc_reg < $signed({1'b0, geom_i.width});
    assign span     = {geom_i.half, 1'b0};
    assign ring_tmp = 5'(job_i.ring) + 5'(bmf_pkg::RING_ROWS) - 5'(geom_i.half);
    assign area     = bmf_pkg::window_area(geom_i.half);
    assign prod     = {13'b0, sum_reg} * {15'b0, bmf_pkg::area_recip(geom_i.half)};
    assign rem      = sum_reg - bmf_pkg::SUM_W'(q0_reg) * bmf_pkg::SUM_W'(area);

    assign job_ready_o = state_reg == ST_IDLE;
    assign busy_o      = state_reg == ST_SCAN || state_reg == ST_DRAIN;
    assign m_valid     = out_valid_reg;
    assign m_payload   = out_reg;

    always_ff @(posedge aclk) begin
        if (wr_i.en) mem[wr_addr] <= wr_i.data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_en_reg <= (state_reg == ST_SCAN) && in_rng;
            if (rd_en_reg) sum_reg <= sum_reg + bmf_pkg::SUM_W'(rd_data_reg);
            if (out_valid_reg && m_ready && state_reg != ST_HOLD) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid_i) begin
                        rr_reg   <= $signed({2'b0, job_i.row}) - $signed({12'b0, geom_i.half});
                        cc_reg   <= $signed({2'b0, job_i.col}) - $signed({12'b0, geom_i.half});
                        cc0_reg  <= $signed({2'b0, job_i.col}) - $signed({12'b0, geom_i.half});
                        ring_reg <= (ring_tmp >= 5'(bmf_pkg::RING_ROWS)) ?
                                    4'(ring_tmp - 5'(bmf_pkg::RING_ROWS)) : 4'(ring_tmp);
                        dr_reg        <= '0;
                        dc_reg        <= '0;
                        sum_reg       <= '0;
                        row_end_reg   <= job_i.row_end;
                        image_end_reg <= job_i.image_end;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (dc_reg == span) begin
                        dc_reg   <= '0;
                        cc_reg   <= cc0_reg;
                        dr_reg   <= dr_reg + 1'b1;
                        rr_reg   <= rr_reg + 15'sd1;
                        ring_reg <= (ring_reg == 4'(bmf_pkg::RING_ROWS - 1)) ?
                                    '0 : ring_reg + 1'b1;
                        if (dr_reg == span) state_reg <= ST_DRAIN;
                    end else begin
                        dc_reg <= dc_reg + 1'b1;
                        cc_reg <= cc_reg + 15'sd1;
                    end
                end
                ST_DRAIN: state_reg <= ST_DIV1;
                ST_DIV1: begin
                    q0_reg    <= prod[23:16];
                    state_reg <= ST_DIV2;
                end
                ST_DIV2: begin
                    mean_reg  <= (rem >= {8'b0, area}) ? q0_reg + 1'b1 : q0_reg;
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= '{mean_value: mean_reg, row_end: row_end_reg,
                                           image_end: image_end_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_i.en |-> !(state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("line store written during window scan");

    a_read_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en_reg |-> $past(state_reg) == ST_SCAN)
        else $error("read data valid outside scan");

    a_hold_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_HOLD && out_valid_reg && !m_ready |=> state_reg == ST_HOLD)
        else $error("result dropped while output stalled");

endmodule

### src/box_mean_filter_2d_unit.sv
// Result path: a producing transaction registers a job in the front end; the back end, when
// idle, takes it, scans every window tap, then passes its drain, divide and hold states.
// Pacing: transactions that produce a result are paced by the single line-store read port,
// walked once per window tap; s_ready is low while the back end scans or drains a window or
// a job waits to be taken, so no transaction of any kind is accepted then.
// Reset: aresetn is synchronous, active low; registers return to half 1, 15x15 image,
// all positions zero. The line store is not cleared.
module box_mean_filter_2d_unit #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HALF  = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bmf_pkg::in_item_t         s_payload,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bmf_pkg::out_item_t        m_payload
);

    logic           back_busy, job_ready, job_valid;
    bmf_pkg::job_t  job;
    bmf_pkg::wr_t   wr;
    bmf_pkg::geom_t geom;

    bmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HALF(MAX_HALF)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .back_busy_i (back_busy),
        .job_ready_i (job_ready),
        .job_valid_o (job_valid),
        .job_o       (job),
        .wr_o        (wr),
        .geom_o      (geom)
    );

    bmf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .geom_i      (geom),
        .wr_i        (wr),
        .job_valid_i (job_valid),
        .job_i       (job),
        .job_ready_o (job_ready),
        .busy_o      (back_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

endmodule
